// File: rtl/core/arfc_pkg.sv
package arfc_pkg;

  localparam int PAYLOAD_DEPTH = 64;
  localparam int CNT_W = 7;
  localparam int IDX_W = 6;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_I      = 8'h49;

  localparam int PREFIX_LEN = 10;

  localparam logic [7:0] PREFIX_A [PREFIX_LEN] = '{
    CH_QUOTE, 8'h70, 8'h61, 8'h72, 8'h61, 8'h6D, 8'h73, CH_QUOTE, CH_COLON, CH_LBRACE
  };
  localparam logic [7:0] PREFIX_B [PREFIX_LEN] = '{
    CH_PLUS, 8'h54, 8'h43, 8'h4D, 8'h51, 8'h54, 8'h54, 8'h52, 8'h45, 8'h43
  };

  typedef enum logic [4:0] {
    ST_IDLE    = 5'd0,
    ST_P1      = 5'd1,
    ST_P2      = 5'd2,
    ST_P3      = 5'd3,
    ST_P4      = 5'd4,
    ST_P5      = 5'd5,
    ST_P6      = 5'd6,
    ST_P7      = 5'd7,
    ST_P8      = 5'd8,
    ST_P9      = 5'd9,
    ST_PAYLOAD = 5'd10,
    ST_S11     = 5'd11,
    ST_S12     = 5'd12,
    ST_S13     = 5'd13,
    ST_S14     = 5'd14,
    ST_S15     = 5'd15,
    ST_S16     = 5'd16,
    ST_S17     = 5'd17,
    ST_S18     = 5'd18
  } state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic             store_valid;
    logic [IDX_W-1:0] store_index;
    logic [7:0]       store_byte;
    logic             frame_done;
    logic [CNT_W-1:0] frame_length;
    logic             frame_dropped;
    logic             overflow;
  } result_t;

  function automatic logic prefix_accepts(logic [3:0] pos, logic [7:0] b);
    logic hit;
    hit = 1'b0;
    if (pos < 4'(PREFIX_LEN)) begin
      hit = (b == PREFIX_A[pos]) || (b == PREFIX_B[pos]);
      if (pos == 4'd7) hit = hit || (b == CH_C) || (b == CH_COLON);
      if (pos == 4'd8) hit = hit || (b == CH_O);
      if (pos == 4'd9) hit = hit || (b == CH_N);
    end
    return hit;
  endfunction

endpackage

// File: rtl/core/arfc_in_stage.sv
module arfc_in_stage import arfc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // Take a new request whenever the held one is empty or moves on this cycle.
  assign in_ready = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item = item_r;

endmodule

// File: rtl/core/arfc_matcher.sv
module arfc_matcher import arfc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output result_t res
);

  state_t           state_r, state_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      count_r <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    logic [CNT_W-1:0] cnt_upd;
    logic             is_end;
    state_nxt = state_r;
    pend_nxt  = pend_r;
    count_nxt = count_r;
    cnt_upd   = count_r;
    is_end    = (item.rx_byte == CH_RBRACE) || (item.rx_byte == CH_LF);
    res       = '0;
    if (item.mode) begin
      pend_nxt = 1'b0;
    end else if (state_r < ST_PAYLOAD) begin
      if (prefix_accepts(state_r[3:0], item.rx_byte)) begin
        state_nxt = state_t'(state_r + 5'd1);
      end else begin
        state_nxt = ST_IDLE;
        count_nxt = '0;
      end
    end else if (state_r == ST_PAYLOAD) begin
      if (pend_r) begin
        // drop the frame: consumer never took the last one
        pend_nxt          = 1'b0;
        res.frame_dropped = 1'b1;
        state_nxt         = ST_IDLE;
        count_nxt         = '0;
      end else begin
        if (count_r < CNT_W'(PAYLOAD_DEPTH)) begin
          res.store_valid = 1'b1;
          res.store_index = count_r[IDX_W-1:0];
          res.store_byte  = item.rx_byte;
          cnt_upd         = count_r + 1'b1;
        end else begin
          res.overflow = 1'b1;
        end
        count_nxt = cnt_upd;
        if (is_end) begin
          pend_nxt         = 1'b1;
          res.frame_done   = 1'b1;
          res.frame_length = cnt_upd;
          state_nxt        = ST_IDLE;
          count_nxt        = '0;
        end else if ((item.rx_byte == CH_O) || (item.rx_byte == CH_N)) begin
          state_nxt = ST_S11;
        end
      end
    end else begin
      // status sub-matcher: advance on a hit, otherwise back to idle
      state_nxt = ST_IDLE;
      unique case (state_r)
        ST_S11: if ((item.rx_byte == CH_N) || (item.rx_byte == CH_COLON)) state_nxt = ST_S12;
        ST_S12: if ((item.rx_byte == CH_N) || (item.rx_byte == CH_O)) state_nxt = ST_S13;
        ST_S13: if (item.rx_byte == CH_E) state_nxt = ST_S14;
        ST_S14: if (item.rx_byte == CH_C) state_nxt = ST_S15;
        ST_S15: if (item.rx_byte == CH_T) state_nxt = ST_S16;
        ST_S16: if (item.rx_byte == CH_I) state_nxt = ST_S17;
        ST_S17: if (item.rx_byte == CH_N) state_nxt = ST_S18;
        default: state_nxt = ST_IDLE;
      endcase
      if (state_nxt == ST_IDLE) count_nxt = '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(PAYLOAD_DEPTH))
    else $error("byte count above buffer depth");

  a_done_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.frame_done |=> pend_r && (state_r == ST_IDLE) && (count_r == '0))
    else $error("closed frame did not leave pending idle state");

  a_drop_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.frame_dropped |=> !pend_r && (state_r == ST_IDLE) && (count_r == '0))
    else $error("dropped frame did not return to idle");

  a_store_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    res.store_valid |-> !res.frame_dropped && !res.overflow && (state_r == ST_PAYLOAD))
    else $error("store outside payload state or with drop/overflow");

endmodule

// File: rtl/core/at_reply_frame_catcher.sv
// Byte-serial catcher for cloud reply frames. Each request is either a received
// UART byte (in_mode 0) or a notice that the pending frame was consumed (in_mode 1),
// and each request yields exactly one result. One request per clock is sustained
// while out_ready keeps the result register free; a request is loaded first into
// the input register and then into the result register, and the matcher state
// advances as the request moves into the result register. Payload
// bytes come out with their index for an external buffer of PAYLOAD_DEPTH bytes;
// a closing brace or line feed reports the frame length and marks the frame
// pending until consumed.
module at_reply_frame_catcher import arfc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_store_valid,
  output logic [IDX_W-1:0]    out_store_index,
  output logic [7:0]          out_store_byte,
  output logic                out_frame_done,
  output logic [CNT_W-1:0]    out_frame_length,
  output logic                out_frame_dropped,
  output logic                out_overflow
);

  logic    advance;
  logic    item_valid;
  item_t   in_item;
  item_t   item;
  result_t res;
  logic    step;
  logic    out_valid_r, out_valid_nxt;
  result_t res_r;

  assign in_item.mode    = in_mode;
  assign in_item.rx_byte = in_rx_byte;

  // Result register frees up when empty or taken this cycle.
  assign advance = !out_valid_r || out_ready;
  assign step    = item_valid && advance;

  arfc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  arfc_matcher u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .res   (res)
  );

  assign out_valid_nxt = advance ? item_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_store_valid   = res_r.store_valid;
  assign out_store_index   = res_r.store_index;
  assign out_store_byte    = res_r.store_byte;
  assign out_frame_done    = res_r.frame_done;
  assign out_frame_length  = res_r.frame_length;
  assign out_frame_dropped = res_r.frame_dropped;
  assign out_overflow      = res_r.overflow;

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("held result lost");

  a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed request produced no result");

  a_ready_when_flowing: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> in_ready)
    else $error("input stalled while result side is free");

endmodule

// File: sim/arfc_tb_pkg.sv
package arfc_tb_pkg;

  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_CONSUME = 1'b1;

  localparam int PFX_CHARS = 10;
  localparam logic [8*PFX_CHARS-1:0] PFX_PARAMS = "\"params\":{";
  localparam logic [8*PFX_CHARS-1:0] PFX_TCMQTT = "+TCMQTTREC";

  // Leftmost character of the literal is position 0.
  function automatic logic [7:0] prefix_char(logic [8*PFX_CHARS-1:0] text, int pos);
    return text[8*(PFX_CHARS-pos)-1 -: 8];
  endfunction

endpackage

// File: sim/arfc_reply_checker.sv
module arfc_reply_checker
  import arfc_pkg::*;
  import arfc_tb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             in_mode,
  input  logic [7:0]       in_rx_byte,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             out_store_valid,
  input  logic [IDX_W-1:0] out_store_index,
  input  logic [7:0]       out_store_byte,
  input  logic             out_frame_done,
  input  logic [CNT_W-1:0] out_frame_length,
  input  logic             out_frame_dropped,
  input  logic             out_overflow,
  output int               mismatch_count,
  output int               replies_pending
);

  result_t          expected_replies[$];
  state_t           cur_state   = ST_IDLE;
  logic             frame_held  = 1'b0;
  logic [CNT_W-1:0] payload_cnt = '0;

  initial begin
    mismatch_count  = 0;
    replies_pending = 0;
  end

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < 50) begin
      $display("%0t: reply mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic logic prefix_match(state_t pos, logic [7:0] b);
    logic hit;
    hit = (b == prefix_char(PFX_PARAMS, int'(pos))) ||
          (b == prefix_char(PFX_TCMQTT, int'(pos)));
    case (pos)
      ST_P7: hit = hit || (b == CH_C) || (b == CH_COLON);
      ST_P8: hit = hit || (b == CH_O);
      ST_P9: hit = hit || (b == CH_N);
      default: ;
    endcase
    return hit;
  endfunction

  function automatic void back_to_idle();
    cur_state   = ST_IDLE;
    payload_cnt = '0;
  endfunction

  function automatic result_t catcher_step(logic consume, logic [7:0] b);
    result_t r;
    state_t  nxt;
    r = '0;
    if (consume) begin
      frame_held = 1'b0;
    end else if (cur_state < ST_PAYLOAD) begin
      if (prefix_match(cur_state, b)) cur_state = state_t'(cur_state + 5'd1);
      else back_to_idle();
    end else if (cur_state == ST_PAYLOAD) begin
      if (frame_held) begin
        // previous frame never consumed: drop it
        frame_held      = 1'b0;
        r.frame_dropped = 1'b1;
        back_to_idle();
      end else begin
        if (payload_cnt < PAYLOAD_DEPTH) begin
          r.store_valid = 1'b1;
          r.store_index = payload_cnt[IDX_W-1:0];
          r.store_byte  = b;
          payload_cnt   = payload_cnt + 1'b1;
        end else begin
          r.overflow = 1'b1;
        end
        if (b == CH_RBRACE || b == CH_LF) begin
          frame_held     = 1'b1;
          r.frame_done   = 1'b1;
          r.frame_length = payload_cnt;
          back_to_idle();
        end else if (b == CH_O || b == CH_N) begin
          cur_state = ST_S11;
        end
      end
    end else begin
      nxt = ST_IDLE;
      case (cur_state)
        ST_S11: if (b == CH_N || b == CH_COLON) nxt = ST_S12;
        ST_S12: if (b == CH_N || b == CH_O) nxt = ST_S13;
        ST_S13: if (b == CH_E) nxt = ST_S14;
        ST_S14: if (b == CH_C) nxt = ST_S15;
        ST_S15: if (b == CH_T) nxt = ST_S16;
        ST_S16: if (b == CH_I) nxt = ST_S17;
        ST_S17: if (b == CH_N) nxt = ST_S18;
        default: ;
      endcase
      if (nxt == ST_IDLE) back_to_idle();
      else cur_state = nxt;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_replies.push_back(catcher_step(in_mode == MODE_CONSUME, in_rx_byte));
      end
      if (out_valid && out_ready) begin
        got.store_valid   = out_store_valid;
        got.store_index   = out_store_index;
        got.store_byte    = out_store_byte;
        got.frame_done    = out_frame_done;
        got.frame_length  = out_frame_length;
        got.frame_dropped = out_frame_dropped;
        got.overflow      = out_overflow;
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with no request outstanding", 1, 0);
        end else begin
          want = expected_replies.pop_front();
          if (got.store_valid !== want.store_valid)
            report_mismatch("store_valid", got.store_valid, want.store_valid);
          if (got.store_index !== want.store_index)
            report_mismatch("store_index", got.store_index, want.store_index);
          if (got.store_byte !== want.store_byte)
            report_mismatch("store_byte", got.store_byte, want.store_byte);
          if (got.frame_done !== want.frame_done)
            report_mismatch("frame_done", got.frame_done, want.frame_done);
          if (got.frame_length !== want.frame_length)
            report_mismatch("frame_length", got.frame_length, want.frame_length);
          if (got.frame_dropped !== want.frame_dropped)
            report_mismatch("frame_dropped", got.frame_dropped, want.frame_dropped);
          if (got.overflow !== want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
        end
      end
      replies_pending = expected_replies.size();
    end
  end

endmodule

// File: sim/tb_top.sv
module tb_top;
  import arfc_pkg::*;
  import arfc_tb_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_mode;
  logic [7:0]       in_rx_byte;
  logic             out_valid;
  logic             out_ready;
  logic             out_store_valid;
  logic [IDX_W-1:0] out_store_index;
  logic [7:0]       out_store_byte;
  logic             out_frame_done;
  logic [CNT_W-1:0] out_frame_length;
  logic             out_frame_dropped;
  logic             out_overflow;

  int mismatch_count;
  int replies_pending;
  int sent      = 0;
  int taken     = 0;
  int send_calm = 0;
  int take_calm = 0;

  at_reply_frame_catcher i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_store_valid   (out_store_valid),
    .out_store_index   (out_store_index),
    .out_store_byte    (out_store_byte),
    .out_frame_done    (out_frame_done),
    .out_frame_length  (out_frame_length),
    .out_frame_dropped (out_frame_dropped),
    .out_overflow      (out_overflow)
  );

  arfc_reply_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_store_valid   (out_store_valid),
    .out_store_index   (out_store_index),
    .out_store_byte    (out_store_byte),
    .out_frame_done    (out_frame_done),
    .out_frame_length  (out_frame_length),
    .out_frame_dropped (out_frame_dropped),
    .out_overflow      (out_overflow),
    .mismatch_count    (mismatch_count),
    .replies_pending   (replies_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("** at_reply_frame_catcher: FAILED **");
    $finish;
  end

  // Idle cycles before the next request; now and then a run with no idling.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 11);
  endfunction

  // Starts and ends at a falling edge; valid stays high after acceptance
  // until the next call or an explicit drop.
  task automatic send_request(logic mode, logic [7:0] b);
    int gap;
    gap = draw_gap(send_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode    <= mode;
    in_rx_byte <= b;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_request(MODE_BYTE, b);
  endtask

  task automatic send_consume();
    send_request(MODE_CONSUME, 8'($urandom));
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    wait (replies_pending == 0);
    @(negedge clk);
  endtask

  function automatic logic [7:0] prefix_letter(int pos);
    int pick;
    pick = $urandom_range(0, 5);
    if (pick == 5) begin
      if (pos == 7) return ($urandom_range(0, 1) != 0) ? CH_C : CH_COLON;
      if (pos == 8) return CH_O;
      if (pos == 9) return CH_N;
    end
    return pick[0] ? prefix_char(PFX_TCMQTT, pos) : prefix_char(PFX_PARAMS, pos);
  endfunction

  function automatic logic [7:0] sub_letter(int step);
    case (step)
      0:       return ($urandom_range(0, 1) != 0) ? CH_N : CH_COLON;
      1:       return ($urandom_range(0, 1) != 0) ? CH_N : CH_O;
      2:       return CH_E;
      3:       return CH_C;
      4:       return CH_T;
      5:       return CH_I;
      default: return CH_N;
    endcase
  endfunction

  // Payload byte that neither closes the frame nor enters the sub-matcher.
  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_RBRACE || b == CH_LF || b == CH_O || b == CH_N);
    return b;
  endfunction

  task automatic send_prefix();
    for (int p = 0; p < PFX_CHARS; p++) send_byte(prefix_letter(p));
  endtask

  task automatic send_frame();
    int len;
    len = ($urandom_range(0, 6) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 10);
    send_prefix();
    repeat (len) send_byte(($urandom_range(0, 19) == 0) ? 8'($urandom) : filler_byte());
    send_byte(($urandom_range(0, 1) != 0) ? CH_RBRACE : CH_LF);
    // leave some frames unconsumed so the next payload byte drops them
    if ($urandom_range(0, 3) != 0) send_consume();
  endtask

  task automatic send_sub_walk();
    int steps;
    send_prefix();
    repeat ($urandom_range(0, 3)) send_byte(filler_byte());
    send_byte(($urandom_range(0, 1) != 0) ? CH_O : CH_N);
    steps = $urandom_range(0, 7);
    for (int k = 0; k < steps; k++) send_byte(sub_letter(k));
    send_byte(8'($urandom));
  endtask

  task automatic send_broken_prefix();
    int n;
    n = $urandom_range(0, PFX_CHARS - 1);
    for (int p = 0; p < n; p++) send_byte(prefix_letter(p));
    send_byte(8'($urandom));
  endtask

  // Receiver: per-reply stall, one long hold-off to back up the block.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      gap = (taken == 120) ? 300 : draw_gap(take_calm);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
    end
  end

  initial begin
    int  kind;
    bit  paused;
    paused     = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_mode    = MODE_BYTE;
    in_rx_byte = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // params frame with extreme payload bytes, then a second frame whose first
    // payload byte meets the unconsumed one, then a consume with nothing held
    for (int p = 0; p < PFX_CHARS; p++) send_byte(prefix_char(PFX_PARAMS, p));
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_RBRACE);
    for (int p = 0; p < PFX_CHARS; p++) send_byte(prefix_char(PFX_TCMQTT, p));
    send_byte(8'h41);
    send_consume();
    drain_pause();

    while (sent < 850) begin
      if (!paused && sent >= 450) begin
        drain_pause();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) send_frame();
      else if (kind < 70) send_sub_walk();
      else if (kind < 85) send_broken_prefix();
      else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 4) == 0) send_consume();
          else send_byte(8'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    wait (replies_pending == 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** at_reply_frame_catcher: PASSED **");
    end else begin
      $display("** at_reply_frame_catcher: FAILED **");
    end
    $finish;
  end

endmodule
